// ----- rtl/kdlr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlr_pkg
// Shared types, register indexes and event code helpers for the key
// debounce / long-press / auto-repeat core.
// ----------------------------------------------------------------------------
package kdlr_pkg;

  localparam int MASK_W     = 8;
  localparam int CODE_W     = 5;
  localparam int KEYIDX_W   = 3;
  localparam int FILT_W     = 7;
  localparam int FCNT_W     = 8;
  localparam int LONG_W     = 16;
  localparam int RPT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPEED = 2'd2;

  localparam logic [FILT_W-1:0] FILTER_TIME_RST  = 7'd5;
  localparam logic [LONG_W-1:0] LONG_TIME_RST    = 16'd100;
  localparam logic [RPT_W-1:0]  REPEAT_SPEED_RST = 8'd0;
  localparam logic [FCNT_W-1:0] FILTER_COUNT_RST = 8'd2;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2,
    EV_LONG = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [FILT_W-1:0] filter_time;
    logic [LONG_W-1:0] long_time;
    logic [RPT_W-1:0]  repeat_speed;
  } cfg_t;

  // per-key results of one tick: primary slot (down or up) and extra slot
  // (long or repeat down)
  typedef struct packed {
    logic prim;
    logic prim_up;
    logic extra;
    logic extra_long;
  } lane_ev_t;

  function automatic logic [CODE_W-1:0] event_code(input logic [KEYIDX_W-1:0] key,
                                                   input ev_kind_t kind);
    logic [CODE_W-1:0] base;
    base = CODE_W'(key) + CODE_W'(key) + CODE_W'(key);
    return base + CODE_W'(kind);
  endfunction

endpackage

// ----- rtl/key_debounce_long_repeat_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_repeat_core
// Debounce with long-press and auto-repeat events for up to eight keys.
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   s_tdata[7:0]  pressed_mask
//   m_*      out  m_tvalid / m_tready   m_tdata[4:0]  event_code, m_tlast
//   cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// All key lanes update in the cycle a scan tick is accepted; the tick's
// events (0 to 2*NUM_KEYS) then leave one per cycle, while m_tready is high,
// through the output register. The next tick is taken in the cycle after the
// previous tick's last event has moved into the output register. m_tready
// low holds the output and backs up s_tready.
// rst is synchronous; config writes are always ready.
// ----------------------------------------------------------------------------
module key_debounce_long_repeat_core #(
  parameter int NUM_KEYS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] pressed_mask
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // [4:0] event_code, [7:5] zero
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kdlr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  kdlr_pkg::cfg_t                    cfg;
  kdlr_pkg::lane_ev_t [NUM_KEYS-1:0] ev;
  logic                              busy;
  logic                              tick;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign tick      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_time  <= kdlr_pkg::FILTER_TIME_RST;
      cfg.long_time    <= kdlr_pkg::LONG_TIME_RST;
      cfg.repeat_speed <= kdlr_pkg::REPEAT_SPEED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kdlr_pkg::REG_FILTER_TIME: begin
          cfg.filter_time <= cfg_data[kdlr_pkg::FILT_W-1:0];
        end
        kdlr_pkg::REG_LONG_TIME: begin
          cfg.long_time <= cfg_data[kdlr_pkg::LONG_W-1:0];
        end
        kdlr_pkg::REG_REPEAT_SPEED: begin
          cfg.repeat_speed <= cfg_data[kdlr_pkg::RPT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdlr_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .tick    (tick),
      .pressed (s_tdata[k]),
      .cfg     (cfg),
      .ev      (ev[k])
    );
  end

  kdlr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (tick),
    .ev       (ev),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/kdlr_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlr_lane
// One key: debounce filter counter, hold counter and repeat counter. State
// advances on each accepted scan tick; event flags are valid in that cycle.
// ----------------------------------------------------------------------------
module kdlr_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               pressed,
  input  kdlr_pkg::cfg_t     cfg,
  output kdlr_pkg::lane_ev_t ev
);

  logic [kdlr_pkg::FCNT_W-1:0] filter_count, filter_count_next;
  logic                        key_is_down, key_is_down_next;
  logic [kdlr_pkg::LONG_W-1:0] hold_count, hold_count_next;
  logic [kdlr_pkg::RPT_W-1:0]  repeat_count, repeat_count_next;

  logic [kdlr_pkg::FCNT_W-1:0] ft;
  logic [kdlr_pkg::FCNT_W-1:0] top;
  logic [kdlr_pkg::LONG_W-1:0] hold_inc;
  logic [kdlr_pkg::RPT_W:0]    rpt_inc;

  assign ft       = {1'b0, cfg.filter_time};
  assign top      = {cfg.filter_time, 1'b0};
  assign hold_inc = hold_count + 1'b1;
  assign rpt_inc  = {1'b0, repeat_count} + 1'b1;

  always_comb begin
    filter_count_next = filter_count;
    key_is_down_next  = key_is_down;
    hold_count_next   = hold_count;
    repeat_count_next = repeat_count;
    ev                = '0;
    if (pressed) begin
      if (filter_count < ft) begin
        filter_count_next = ft;
      end else if (filter_count < top) begin
        filter_count_next = filter_count + 1'b1;
      end else begin
        if (!key_is_down) begin
          key_is_down_next = 1'b1;
          ev.prim          = 1'b1;
        end
        if (cfg.long_time != '0) begin
          if (hold_count < cfg.long_time) begin
            hold_count_next = hold_inc;
            if (hold_inc == cfg.long_time) begin
              ev.extra      = 1'b1;
              ev.extra_long = 1'b1;
            end
          end else if (cfg.repeat_speed != '0) begin
            if (rpt_inc >= {1'b0, cfg.repeat_speed}) begin
              repeat_count_next = '0;
              ev.extra          = 1'b1;
            end else begin
              repeat_count_next = rpt_inc[kdlr_pkg::RPT_W-1:0];
            end
          end
        end
      end
    end else begin
      if (filter_count > ft) begin
        filter_count_next = ft;
      end else if (filter_count != '0) begin
        filter_count_next = filter_count - 1'b1;
      end else if (key_is_down) begin
        key_is_down_next = 1'b0;
        ev.prim          = 1'b1;
        ev.prim_up       = 1'b1;
      end
      hold_count_next   = '0;
      repeat_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count <= kdlr_pkg::FILTER_COUNT_RST;
      key_is_down  <= 1'b0;
      hold_count   <= '0;
      repeat_count <= '0;
    end else if (tick) begin
      filter_count <= filter_count_next;
      key_is_down  <= key_is_down_next;
      hold_count   <= hold_count_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

// ----- rtl/kdlr_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlr_merge
// Collects the lane events of one tick and sends them out one per cycle,
// while the output is not stalled, in key order through an output register.
// ----------------------------------------------------------------------------
module kdlr_merge #(
  parameter int NUM_KEYS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  kdlr_pkg::lane_ev_t [NUM_KEYS-1:0]    ev,
  output logic                                 busy,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,
  output logic                                 m_tlast
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] pend_prim, pend_extra;
  logic [NUM_KEYS-1:0] prim_up, extra_long;

  logic [KW-1:0]       sel_key;
  logic                sel_extra;
  logic [NUM_KEYS-1:0] clr_prim, clr_extra;
  logic                any_pend;
  logic                take;
  logic                last;
  kdlr_pkg::ev_kind_t  sel_kind;
  logic [kdlr_pkg::CODE_W-1:0] code;

  assign any_pend = (|pend_prim) | (|pend_extra);
  assign busy     = any_pend;
  assign take     = any_pend && (!m_tvalid || m_tready);

  always_comb begin
    sel_key   = '0;
    sel_extra = 1'b0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pend_extra[k]) begin
        sel_key   = KW'(k);
        sel_extra = 1'b1;
      end
      if (pend_prim[k]) begin
        sel_key   = KW'(k);
        sel_extra = 1'b0;
      end
    end
  end

  always_comb begin
    clr_prim  = '0;
    clr_extra = '0;
    if (sel_extra) begin
      clr_extra[sel_key] = 1'b1;
    end else begin
      clr_prim[sel_key] = 1'b1;
    end
  end

  assign last = ((pend_prim & ~clr_prim) == '0) && ((pend_extra & ~clr_extra) == '0);

  always_comb begin
    if (sel_extra) begin
      sel_kind = extra_long[sel_key] ? kdlr_pkg::EV_LONG : kdlr_pkg::EV_DOWN;
    end else begin
      sel_kind = prim_up[sel_key] ? kdlr_pkg::EV_UP : kdlr_pkg::EV_DOWN;
    end
  end

  assign code = kdlr_pkg::event_code(kdlr_pkg::KEYIDX_W'(sel_key), sel_kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_prim  <= '0;
      pend_extra <= '0;
    end else if (load) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pend_prim[k]  <= ev[k].prim;
        pend_extra[k] <= ev[k].extra;
      end
    end else if (take) begin
      pend_prim  <= pend_prim & ~clr_prim;
      pend_extra <= pend_extra & ~clr_extra;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        prim_up[k]    <= ev[k].prim_up;
        extra_long[k] <= ev[k].extra_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {{(8 - kdlr_pkg::CODE_W){1'b0}}, code};
      m_tlast <= last;
    end
  end

endmodule

// ----- tb/key_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the scan, event and config channels of the key debounce core. Each
// accepted scan tick runs through a per-key model of the filter, hold and
// repeat counters, and the events it yields are queued. Each event
// transaction is compared against the oldest queued event (code and last
// flag). Reports the running failure count and the number of events still
// pending.
// ----------------------------------------------------------------------------
module key_event_checker #(
  parameter int NUM_KEYS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] pressed_mask
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [7:0]                        m_tdata,   // [4:0] event_code
  input  logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdlr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                errors,
  output int                                pending
);

  localparam logic [kdlr_pkg::FCNT_W-1:0] FILT_START = 8'd2;

  typedef struct packed {
    logic [kdlr_pkg::CODE_W-1:0] code;
    logic                        last;
  } key_event_t;

  kdlr_pkg::cfg_t              settings;
  logic [kdlr_pkg::FCNT_W-1:0] filt_cnt [NUM_KEYS];
  logic                        key_down [NUM_KEYS];
  logic [kdlr_pkg::LONG_W-1:0] hold_cnt [NUM_KEYS];
  logic [kdlr_pkg::RPT_W-1:0]  rpt_cnt  [NUM_KEYS];

  key_event_t expected_events [$];
  key_event_t want;
  int         fails = 0;

  function automatic void predict_scan_tick(input logic [7:0] mask);
    logic [kdlr_pkg::CODE_W-1:0] codes [2*NUM_KEYS];
    key_event_t        ev;
    int                n;
    int                ft;
    int                top;
    int                lt;
    int                rs;
    int                r;
    n   = 0;
    ft  = int'(settings.filter_time);
    top = 2 * ft;
    lt  = int'(settings.long_time);
    rs  = int'(settings.repeat_speed);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (mask[k]) begin
        if (int'(filt_cnt[k]) < ft) begin
          filt_cnt[k] = kdlr_pkg::FCNT_W'(ft);
        end else if (int'(filt_cnt[k]) < top) begin
          filt_cnt[k] = filt_cnt[k] + 1'b1;
        end else begin
          if (!key_down[k]) begin
            key_down[k] = 1'b1;
            codes[n] = kdlr_pkg::CODE_W'(3 * k + int'(kdlr_pkg::EV_DOWN));
            n++;
          end
          if (lt > 0) begin
            if (int'(hold_cnt[k]) < lt) begin
              hold_cnt[k] = hold_cnt[k] + 1'b1;
              if (int'(hold_cnt[k]) == lt) begin
                codes[n] = kdlr_pkg::CODE_W'(3 * k + int'(kdlr_pkg::EV_LONG));
                n++;
              end
            end else if (rs > 0) begin
              r = int'(rpt_cnt[k]) + 1;
              if (r >= rs) begin
                rpt_cnt[k] = '0;
                codes[n] = kdlr_pkg::CODE_W'(3 * k + int'(kdlr_pkg::EV_DOWN));
                n++;
              end else begin
                rpt_cnt[k] = kdlr_pkg::RPT_W'(r);
              end
            end
          end
        end
      end else begin
        if (int'(filt_cnt[k]) > ft) begin
          filt_cnt[k] = kdlr_pkg::FCNT_W'(ft);
        end else if (filt_cnt[k] != '0) begin
          filt_cnt[k] = filt_cnt[k] - 1'b1;
        end else if (key_down[k]) begin
          key_down[k] = 1'b0;
          codes[n] = kdlr_pkg::CODE_W'(3 * k + int'(kdlr_pkg::EV_UP));
          n++;
        end
        hold_cnt[k] = '0;
        rpt_cnt[k]  = '0;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev.code = codes[i];
      ev.last = (i == n - 1);
      expected_events.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings.filter_time  = kdlr_pkg::FILTER_TIME_RST;
      settings.long_time    = kdlr_pkg::LONG_TIME_RST;
      settings.repeat_speed = kdlr_pkg::REPEAT_SPEED_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
        filt_cnt[k] = FILT_START;
        key_down[k] = 1'b0;
        hold_cnt[k] = '0;
        rpt_cnt[k]  = '0;
      end
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kdlr_pkg::REG_FILTER_TIME:
            settings.filter_time  = cfg_data[kdlr_pkg::FILT_W-1:0];
          kdlr_pkg::REG_LONG_TIME:
            settings.long_time    = cfg_data[kdlr_pkg::LONG_W-1:0];
          kdlr_pkg::REG_REPEAT_SPEED:
            settings.repeat_speed = cfg_data[kdlr_pkg::RPT_W-1:0];
          default: ;
        endcase
      end
      // event leaving now belongs to an earlier tick, so pop before predicting
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, code %0d last %0b", $time,
                   m_tdata[kdlr_pkg::CODE_W-1:0], m_tlast);
          fails++;
        end else begin
          want = expected_events.pop_front();
          if (m_tdata[kdlr_pkg::CODE_W-1:0] !== want.code || m_tlast !== want.last) begin
            $display("%0t: event mismatch, expected code %0d last %0b, got code %0d last %0b",
                     $time, want.code, want.last, m_tdata[kdlr_pkg::CODE_W-1:0], m_tlast);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_scan_tick(s_tdata);
    end
    errors  <= fails;
    pending <= expected_events.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for key_debounce_long_repeat_core. Drives scan ticks
// as directed patterns and then random held key masks with occasional
// bounce, across several register settings (including filter time zero, the
// largest values and changes with keys held), with random gaps and output
// stalls. key_event_checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [kdlr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic [7:0]                      s_tdata   = '0;
  logic                            m_tready  = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic [kdlr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kdlr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  wire                             s_tready;
  wire                             m_tvalid;
  wire  [7:0]                      m_tdata;
  wire                             m_tlast;
  wire                             cfg_ready;
  int                              errors;
  int                              pending;
  bit                              calm      = 1'b0;
  int                              stall_left = 0;
  int                              quiet     = 0;

  always #6 clk = ~clk;

  key_debounce_long_repeat_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  key_event_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_tick(input logic [7:0] mask);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mask;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold random masks for random runs, with a bounced key now and then
  task automatic run_holds(input int count, input int max_hold);
    int         left;
    int         len;
    logic [7:0] held;
    logic [7:0] mask;
    left = count;
    while (left > 0) begin
      held = 8'($urandom);
      len  = $urandom_range(1, max_hold);
      for (int i = 0; i < len && left > 0; i++) begin
        mask = held;
        if ($urandom_range(0, 7) == 0) mask = held ^ (8'h01 << $urandom_range(0, 7));
        send_tick(mask);
        left--;
      end
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kdlr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdlr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [kdlr_pkg::FILT_W-1:0] ft,
                               input logic [kdlr_pkg::LONG_W-1:0] lt,
                               input logic [kdlr_pkg::RPT_W-1:0]  rs);
    logic [kdlr_pkg::CFG_DATA_W-1:0] junk;
    junk = kdlr_pkg::CFG_DATA_W'($urandom);
    write_reg(kdlr_pkg::REG_FILTER_TIME,
              {junk[kdlr_pkg::CFG_DATA_W-1:kdlr_pkg::FILT_W], ft});
    write_reg(kdlr_pkg::REG_LONG_TIME, lt);
    write_reg(kdlr_pkg::REG_REPEAT_SPEED,
              {junk[kdlr_pkg::CFG_DATA_W-1:kdlr_pkg::RPT_W], rs});
    write_reg(REG_UNUSED, junk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: all keys down, all keys up, single and alternating keys
    send_tick(8'h00);
    repeat (8) send_tick(8'hFF);
    repeat (8) send_tick(8'h00);
    send_tick(8'h55);
    send_tick(8'hAA);
    send_tick(8'h01);
    send_tick(8'h80);
    send_tick(8'hFE);
    wait_idle();

    load_settings(7'd2, 16'd4, 8'd2);
    run_holds(60, 14);
    wait_idle();

    // zero filter, long on the first held tick and repeat on every held tick after
    load_settings(7'd0, 16'd1, 8'd1);
    run_holds(25, 6);
    wait_idle();

    // long press disabled
    load_settings(7'd3, 16'd0, 8'd7);
    run_holds(25, 12);
    wait_idle();

    load_settings(7'd127, 16'hFFFF, 8'hFF);
    run_holds(10, 4);
    repeat (12) send_tick(8'hFF);
    wait_idle();

    // counters above the new top: keys go down on the next held tick
    load_settings(7'd6, 16'd40, 8'd200);
    repeat (50) send_tick(8'hFF);
    wait_idle();

    // hold and repeat counters already past the new limits
    calm = 1'b1;
    load_settings(7'd6, 16'd10, 8'd5);
    repeat (6) send_tick(8'hFF);
    run_holds(30, 10);
    wait_idle();

    if (errors == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
